FILE: hw/rtl/histogram_equalizer_macros.svh
// Assertion helpers used by the checker module.
`ifndef HISTOGRAM_EQUALIZER_MACROS_SVH
`define HISTOGRAM_EQUALIZER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define HQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define HQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/histeq_pkg.sv
`timescale 1ns / 1ps
package histeq_pkg;
  localparam int LEVELS         = 256;
  localparam int TOP_LEVEL      = 255;
  localparam int PIX_W          = 8;
  localparam int IMAGE_SIDE_DEF = 32;

  // request modes
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_COUNT = 2'd1;
  localparam logic [1:0] MODE_MAP   = 2'd2;
endpackage

FILE: hw/rtl/histeq_div.sv
`timescale 1ns / 1ps
// Computes floor(diff * 255 / span), one quotient bit per cycle.
// Valid only for diff <= span, span != 0 (quotient fits 8 bits).
module histeq_div
  import histeq_pkg::*;
#(
  parameter int CNT_W = 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [CNT_W-1:0]     diff,
  input  logic [CNT_W-1:0]     span,
  output logic                 done,
  output logic [PIX_W-1:0]     quot
);
  localparam int NUM_W = CNT_W + PIX_W;

  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] dv_r;
  logic [PIX_W-1:0] q_r;
  logic [2:0]       step_r;
  logic             busy_r;
  logic             done_r;
  logic             fits;

  assign fits = (num_r >= dv_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 3'd7;
        q_r    <= '0;
        num_r  <= NUM_W'(diff) * NUM_W'(TOP_LEVEL);
        dv_r   <= NUM_W'({span, 7'b0});
      end else if (busy_r) begin
        // restoring step
        if (fits) begin
          num_r <= num_r - dv_r;
        end
        q_r  <= {q_r[PIX_W-2:0], fits};
        dv_r <= dv_r >> 1;
        step_r <= step_r - 3'd1;
        if (step_r == 3'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

FILE: hw/rtl/histogram_equalizer.sv
`timescale 1ns / 1ps
// Grayscale histogram equalizer. A clear request completes in the IDLE state, a count
// request is a read-modify-write of the bin memory (counts past IMAGE_SIDE^2 pixels are
// dropped in IDLE), and a map request reads the level map, then waits for the result to
// be taken. The first map request after counting or a clear first rebuilds the 256-entry
// level map: one bin read, one accumulate, one divider start and the bit-serial divide
// per level, then one map read for the pending pixel. Bin counts clear through per-bin
// valid bits rather than writes to the bin memory.
module histogram_equalizer
  import histeq_pkg::*;
#(
  parameter int IMAGE_SIDE = IMAGE_SIDE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_mode,
  input  logic [PIX_W-1:0] in_pixel,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] out_mapped_pixel
);
  localparam int PIXEL_TOTAL = IMAGE_SIDE * IMAGE_SIDE;
  localparam int CNT_W       = $clog2(PIXEL_TOTAL + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CNT_WR, S_MAP_RD, S_MAP_OUT, S_B_RD, S_B_ACC, S_B_GO, S_B_DIV
  } state_t;

  state_t           state_r;
  logic [PIX_W-1:0] pix_r;
  logic [PIX_W-1:0] idx_r;
  logic [CNT_W-1:0] counted_r;
  logic             built_r;
  logic [LEVELS-1:0] vld_r;
  logic [CNT_W-1:0] cdf_r;
  logic [CNT_W-1:0] cdf_min_r;
  logic             seen_r;
  logic [CNT_W-1:0] diff_r;
  logic             span_zero_r;
  logic             out_valid_r;
  logic [PIX_W-1:0] out_pix_r;

  // memories
  logic [CNT_W-1:0] bin_mem [LEVELS];
  logic [PIX_W-1:0] map_mem [LEVELS];
  logic [CNT_W-1:0] bin_rd_r;
  logic             bin_rd_vld_r;
  logic [PIX_W-1:0] map_rd_r;

  logic             accept;
  logic             bin_re, bin_we, map_re, map_we;
  logic [PIX_W-1:0] bin_addr, map_addr;
  logic [CNT_W-1:0] bin_val, bin_wdata;
  logic [PIX_W-1:0] map_wdata;
  logic [CNT_W-1:0] cdf_sum, cdf_min_new, span;
  logic             div_start, div_done;
  logic [PIX_W-1:0] div_quot;
  logic             out_free;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign bin_val  = bin_rd_vld_r ? bin_rd_r : '0;

  // memory port control
  always_comb begin
    bin_re    = 1'b0;
    bin_we    = 1'b0;
    bin_addr  = idx_r;
    map_re    = 1'b0;
    map_we    = 1'b0;
    map_addr  = idx_r;
    bin_wdata = bin_val + CNT_W'(1);
    map_wdata = span_zero_r ? '0 : div_quot;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_mode == MODE_COUNT && counted_r < CNT_W'(PIXEL_TOTAL)) begin
          bin_re   = 1'b1;
          bin_addr = in_pixel;
        end else if (accept && in_mode == MODE_MAP && built_r) begin
          map_re   = 1'b1;
          map_addr = in_pixel;
        end
      end
      S_CNT_WR: begin
        bin_we   = 1'b1;
        bin_addr = pix_r;
      end
      // pending lookup once the map is complete; idx_r holds the pixel
      S_MAP_RD: map_re = 1'b1;
      S_B_RD:  bin_re = 1'b1;
      S_B_GO:  div_start = 1'b1;
      S_B_DIV: begin
        if (div_done) map_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (bin_we) bin_mem[bin_addr] <= bin_wdata;
    if (bin_re) begin
      bin_rd_r     <= bin_mem[bin_addr];
      bin_rd_vld_r <= vld_r[bin_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_addr] <= map_wdata;
    if (map_re) map_rd_r <= map_mem[map_addr];
  end

  // running cumulative sum during the build
  assign cdf_sum     = cdf_r + bin_val;
  assign cdf_min_new = (!seen_r && cdf_sum != '0) ? cdf_sum : cdf_min_r;
  assign span        = CNT_W'(PIXEL_TOTAL) - cdf_min_r;

  histeq_div #(.CNT_W(CNT_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .diff  (diff_r),
    .span  (span),
    .done  (div_done),
    .quot  (div_quot)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      counted_r   <= '0;
      built_r     <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_MAP_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            pix_r <= in_pixel;
            case (in_mode)
              MODE_CLEAR: begin
                vld_r     <= '0;
                counted_r <= '0;
                built_r   <= 1'b0;
              end
              MODE_COUNT: begin
                if (counted_r < CNT_W'(PIXEL_TOTAL)) state_r <= S_CNT_WR;
              end
              MODE_MAP: begin
                if (built_r) begin
                  state_r <= S_MAP_OUT;
                end else begin
                  idx_r     <= '0;
                  cdf_r     <= '0;
                  cdf_min_r <= '0;
                  seen_r    <= 1'b0;
                  state_r   <= S_B_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_CNT_WR: begin
          vld_r[pix_r] <= 1'b1;
          counted_r    <= counted_r + CNT_W'(1);
          built_r      <= 1'b0;
          state_r      <= S_IDLE;
        end
        S_B_RD: state_r <= S_B_ACC;
        S_B_ACC: begin
          cdf_r     <= cdf_sum;
          cdf_min_r <= cdf_min_new;
          if (cdf_sum != '0) seen_r <= 1'b1;
          diff_r    <= cdf_sum - cdf_min_new;
          state_r   <= S_B_GO;
        end
        S_B_GO: begin
          span_zero_r <= (cdf_min_r >= CNT_W'(PIXEL_TOTAL));
          state_r     <= S_B_DIV;
        end
        S_B_DIV: begin
          if (div_done) begin
            if (idx_r == PIX_W'(LEVELS - 1)) begin
              built_r <= 1'b1;
              idx_r   <= pix_r;
              state_r <= S_MAP_RD;
            end else begin
              idx_r   <= idx_r + PIX_W'(1);
              state_r <= S_B_RD;
            end
          end
        end
        S_MAP_RD: state_r <= S_MAP_OUT;
        S_MAP_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_pix_r   <= map_rd_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mapped_pixel = out_pix_r;
endmodule

FILE: hw/rtl/histeq_chk.sv
`timescale 1ns / 1ps
`include "histogram_equalizer_macros.svh"
// Port-level checks for the equalizer.
module histeq_chk
  import histeq_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic [1:0]       in_mode,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] out_mapped_pixel
);
  `HQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_mapped_pixel), "result dropped or changed while stalled")
  `HQ_ASSERT_NEXT(a_map_busy, clk, rst_n, in_valid && in_ready && in_mode == MODE_MAP, !in_ready, "map request did not occupy the block")
  `HQ_ASSERT_NEXT(a_clear_fast, clk, rst_n, in_valid && in_ready && in_mode == MODE_CLEAR, in_ready, "clear request took more than one cycle")
  `HQ_ASSERT_IMPLY(a_result_src, clk, rst_n, $rose(out_valid), $past(!in_ready), "result appeared without a map request in flight")
endmodule

bind histogram_equalizer histeq_chk u_histeq_chk (.*);

FILE: tb/sv/tb_histogram_equalizer.sv
`timescale 1ns / 1ps
module tb_histogram_equalizer;
  import histeq_pkg::*;

  localparam int SIDE = 32;
  localparam int PIXEL_TOTAL = SIDE * SIDE;
  localparam logic [1:0] MODE_IDLE = 2'd3;  // unused mode, ignored by the block

  typedef struct {
    logic [1:0]       mode;
    logic [PIX_W-1:0] pixel;
    bit               drain;  // hold until every mapped pixel is back
  } pix_req_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [1:0]       in_mode;
  logic [PIX_W-1:0] in_pixel;
  logic             out_valid;
  logic             out_ready;
  logic [PIX_W-1:0] out_mapped_pixel;

  histogram_equalizer #(.IMAGE_SIDE(SIDE)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode), .in_pixel(in_pixel),
    .out_valid(out_valid), .out_ready(out_ready), .out_mapped_pixel(out_mapped_pixel)
  );

  pix_req_t         pending_reqs[$];
  logic [PIX_W-1:0] expected_mapped[$];
  int               error_count = 0;

  // predictor state
  int unsigned      hist_bins[LEVELS];
  logic [PIX_W-1:0] eq_lut[LEVELS];
  int unsigned      pixels_seen;
  bit               lut_valid;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // equalization table from the current histogram
  function automatic void rebuild_lut();
    int unsigned cum[LEVELS];
    int unsigned acc, first_cum, span, v;
    bit found;
    acc = 0;
    first_cum = 0;
    found = 0;
    for (int i = 0; i < LEVELS; i++) begin
      acc += hist_bins[i];
      cum[i] = acc;
      if (!found && acc != 0) begin
        first_cum = acc;
        found = 1;
      end
    end
    span = (PIXEL_TOTAL > first_cum) ? PIXEL_TOTAL - first_cum : 0;
    for (int i = 0; i < LEVELS; i++) begin
      v = 0;
      if (span != 0 && cum[i] > first_cum) begin
        v = ((cum[i] - first_cum) * TOP_LEVEL) / span;
        if (v > TOP_LEVEL) v = TOP_LEVEL;
      end
      eq_lut[i] = v[PIX_W-1:0];
    end
    lut_valid = 1;
  endfunction

  function automatic void apply_request(logic [1:0] mode, logic [PIX_W-1:0] pixel);
    case (mode)
      MODE_CLEAR: begin
        foreach (hist_bins[i]) hist_bins[i] = 0;
        pixels_seen = 0;
        lut_valid = 0;
      end
      MODE_COUNT: begin
        if (pixels_seen < PIXEL_TOTAL) begin
          hist_bins[pixel]++;
          pixels_seen++;
          lut_valid = 0;
        end
      end
      MODE_MAP: begin
        if (!lut_valid) rebuild_lut();
        expected_mapped.push_back(eq_lut[pixel]);
      end
      default: ;
    endcase
  endfunction

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_req(logic [1:0] mode, logic [PIX_W-1:0] pixel,
                                  bit drain = 0);
    pix_req_t r;
    r.mode = mode;
    r.pixel = pixel;
    r.drain = drain;
    pending_reqs.push_back(r);
  endfunction

  // driver: predicts on acceptance, then presents the next request
  int send_gap = 0;
  always @(posedge clk) begin
    pix_req_t nxt;
    bit busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_mode  <= MODE_CLEAR;
      in_pixel <= '0;
    end else begin
      busy = in_valid && !in_ready;
      if (in_valid && in_ready) apply_request(in_mode, in_pixel);
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].drain && expected_mapped.size() > 0)) begin
          nxt = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_mode  <= nxt.mode;
          in_pixel <= nxt.pixel;
          send_gap = gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks mapped pixels in order, stalls the result side at random
  int recv_gap = 0;
  always @(posedge clk) begin
    logic [PIX_W-1:0] want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_mapped.size() == 0) begin
          $error("unexpected mapped_pixel %0d", out_mapped_pixel);
          error_count++;
        end else begin
          want = expected_mapped.pop_front();
          if (out_mapped_pixel !== want) begin
            $error("mapped_pixel: expected %0d, actual %0d", want, out_mapped_pixel);
            error_count++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_gap = gap_len();
      end
    end
  end

  // map requests may rebuild the whole map, under long result stalls
  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int n_items, n_count, n_map, base, spread;
    logic [PIX_W-1:0] lvl;
    in_valid  = 1'b0;
    in_mode   = MODE_CLEAR;
    in_pixel  = '0;
    out_ready = 1'b0;
    rst_n     = 1'b0;
    foreach (hist_bins[i]) hist_bins[i] = 0;
    pixels_seen = 0;
    lut_valid = 0;

    // directed: empty histogram, unused mode, extreme levels, rebuild after count
    add_req(MODE_MAP, 8'd0);
    add_req(MODE_MAP, 8'd255);
    add_req(MODE_IDLE, 8'd255);
    add_req(MODE_COUNT, 8'd0);
    add_req(MODE_COUNT, 8'd255);
    add_req(MODE_COUNT, 8'd255);
    add_req(MODE_MAP, 8'd0);
    add_req(MODE_MAP, 8'd255);
    add_req(MODE_MAP, 8'd128);
    add_req(MODE_COUNT, 8'd128);
    add_req(MODE_MAP, 8'd128, 1);
    add_req(MODE_MAP, 8'd255);
    add_req(MODE_CLEAR, 8'd0);
    add_req(MODE_COUNT, 8'd7);
    add_req(MODE_MAP, 8'd7);
    add_req(MODE_MAP, 8'd0);   // below the first filled bin
    add_req(MODE_MAP, 8'd200);
    add_req(MODE_IDLE, 8'd0);
    n_items = 18;

    // full single-valued image, with extra counts past the pixel total
    lvl = PIX_W'($urandom_range(0, 255));
    add_req(MODE_CLEAR, 8'd0);
    for (int i = 0; i < PIXEL_TOTAL + 6; i++) add_req(MODE_COUNT, lvl);
    add_req(MODE_MAP, lvl);
    add_req(MODE_MAP, 8'd255 - lvl);
    add_req(MODE_COUNT, 8'd3);  // dropped, table stays
    add_req(MODE_MAP, lvl);
    n_items += PIXEL_TOTAL + 11;

    // random partial images
    while (n_items < 1100) begin
      if ($urandom_range(0, 9) < 8) begin
        add_req(MODE_CLEAR, PIX_W'($urandom()));
        n_count = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
        base = $urandom_range(0, 255);
        spread = $urandom_range(0, 3) == 0 ? 255 : $urandom_range(1, 16);
        for (int i = 0; i < n_count; i++)
          add_req(MODE_COUNT, PIX_W'((base + $urandom_range(0, spread)) % 256));
        n_map = $urandom_range(1, 8);
        for (int i = 0; i < n_map; i++)
          add_req(MODE_MAP, PIX_W'($urandom_range(0, 3) == 0 ?
                  (base + $urandom_range(0, spread)) % 256 : $urandom()));
        n_items += 1 + n_count + n_map;
      end else begin
        // noise: any mode, any pixel
        for (int i = 0; i < 6; i++)
          add_req(2'($urandom_range(0, 3)), PIX_W'($urandom()));
        n_items += 6;
      end
    end
    add_req(MODE_MAP, PIX_W'($urandom()), 1);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_reqs.size() == 0);
    @(posedge clk);
    while (in_valid) @(posedge clk);
    while (expected_mapped.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/histeq_pkg.sv
hw/rtl/histeq_div.sv
hw/rtl/histogram_equalizer.sv
hw/rtl/histeq_chk.sv
tb/sv/tb_histogram_equalizer.sv
